[hdl/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and codes for the rate-monotonic scheduler.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int TASK_IDX_W = 4;
    localparam int TIME_W     = 16;
    localparam int CFG_W      = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load_en;
        logic release_en;
        logic update_en;
        logic found;
    } ctrl_t;

    typedef struct packed {
        logic [TIME_W-1:0]     period;
        logic [TIME_W-1:0]     exec;
        logic [TASK_IDX_W-1:0] idx;
    } load_t;

endpackage

[hdl/rms_cell.sv]
// ----------------------------------------------------------------------------
// rms_cell
// One task entry: table, remaining work, countdown, and one hop of the
// shortest-period search chain.
// ----------------------------------------------------------------------------
module rms_cell
    import rms_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int IDX       = 0,
    parameter int IW        = 4,
    parameter int CW        = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CW-1:0]     count,
    input  ctrl_t             ctrl,
    input  load_t             load,
    input  logic [IW-1:0]     pick_idx,
    input  logic              in_found,
    input  logic [TIME_W-1:0] in_period,
    input  logic [IW-1:0]     in_idx,
    output logic              out_found,
    output logic [TIME_W-1:0] out_period,
    output logic [IW-1:0]     out_idx
);

    logic [TIME_W-1:0] exec_reg,   exec_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic [TIME_W-1:0] work_reg,   work_next;
    logic [TIME_W-1:0] cd_reg,     cd_next;
    logic              found_reg;
    logic [TIME_W-1:0] cperiod_reg;
    logic [IW-1:0]     cidx_reg;
    logic              active;
    logic              match;
    logic              mine;

    assign active = (32'(count) > IDX);
    assign match  = (32'(load.idx) == IDX);
    assign mine   = active && (work_reg != '0) && (!in_found || (period_reg < in_period));

    always_comb begin
        exec_next   = exec_reg;
        period_next = period_reg;
        work_next   = work_reg;
        cd_next     = cd_reg;
        if (ctrl.load_en && match) begin
            exec_next   = load.exec;
            period_next = load.period;
        end
        if (ctrl.release_en && active && (cd_reg == '0)) begin
            work_next = exec_reg;
            cd_next   = period_reg;
        end
        if (ctrl.update_en && active) begin
            if (ctrl.found && (32'(pick_idx) == IDX)) begin
                work_next = work_reg - 1'b1;
            end
            if (cd_reg != '0) begin
                cd_next = cd_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_reg   <= '0;
            period_reg <= '0;
            work_reg   <= '0;
            cd_reg     <= '0;
            found_reg  <= 1'b0;
        end else begin
            exec_reg   <= exec_next;
            period_reg <= period_next;
            work_reg   <= work_next;
            cd_reg     <= cd_next;
            found_reg  <= mine || in_found;
        end
    end

    always_ff @(posedge aclk) begin
        cperiod_reg <= mine ? period_reg : in_period;
        cidx_reg    <= mine ? IW'(IDX) : in_idx;
    end

    assign out_found  = found_reg;
    assign out_period = cperiod_reg;
    assign out_idx    = cidx_reg;

endmodule

[hdl/rms_ctrl.sv]
// ----------------------------------------------------------------------------
// rms_ctrl
// Tick sequencer (release, chain scan, update) and the result register.
// ----------------------------------------------------------------------------
module rms_ctrl
    import rms_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int IW        = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_cmd,
    output logic                  s_ready,
    input  logic                  res_found,
    input  logic [IW-1:0]         res_idx,
    output ctrl_t                 ctrl,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_busy,
    output logic [TASK_IDX_W-1:0] m_task
);

    state_t                state_reg, state_next;
    logic [IW-1:0]         cnt_reg, cnt_next;
    logic                  out_valid_reg;
    logic                  out_busy_reg;
    logic [TASK_IDX_W-1:0] out_task_reg;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_cmd == CMD_TICK)) state_next = ST_RELEASE;
            end
            ST_RELEASE: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (cnt_reg == IW'(NUM_TASKS - 1)) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        ctrl.load_en    = 1'b0;
        ctrl.release_en = 1'b0;
        ctrl.update_en  = 1'b0;
        ctrl.found      = res_found;
        cnt_next        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.load_en = s_valid && (s_cmd == CMD_LOAD);
            end
            ST_RELEASE: begin
                ctrl.release_en = 1'b1;
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
            end
            ST_UPDATE: begin
                ctrl.update_en = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (ctrl.update_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update_en) begin
            out_busy_reg <= res_found;
            out_task_reg <= res_found ? TASK_IDX_W'(res_idx) : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_busy  = out_busy_reg;
    assign m_task  = out_task_reg;

endmodule

[hdl/rate_monotonic_scheduler_top.sv]
// ----------------------------------------------------------------------------
// rate_monotonic_scheduler_top
// A tick word passes a release state, a scan of the search chain and an
// update state that waits until the result register is free; no new word
// is taken until the tick is done, and a load word is taken while idle.
// Synchronous active-low reset clears the task table, all countdowns and
// the active count.
// ----------------------------------------------------------------------------
module rate_monotonic_scheduler_top
    import rms_pkg::*;
#(
    parameter int NUM_TASKS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata,  // active_task_count
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,    // task_index, exec_time, period_value
    input  logic             s_tuser,    // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,    // running_task
    output logic             m_tuser     // busy_res
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);

    logic [CW-1:0]         count_reg;
    ctrl_t                 ctrl;
    load_t                 load;
    logic                  ch_found  [NUM_TASKS+1];
    logic [TIME_W-1:0]     ch_period [NUM_TASKS+1];
    logic [IW-1:0]         ch_idx    [NUM_TASKS+1];
    logic [TASK_IDX_W-1:0] m_task;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wen) begin
            if (32'(cfg_wdata) > NUM_TASKS) count_reg <= CW'(NUM_TASKS);
            else                            count_reg <= CW'(cfg_wdata);
        end
    end

    assign load.idx    = s_tdata[3:0];
    assign load.exec   = s_tdata[19:4];
    assign load.period = s_tdata[35:20];

    assign ch_found[0]  = 1'b0;
    assign ch_period[0] = '0;
    assign ch_idx[0]    = '0;

    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
        rms_cell #(
            .NUM_TASKS (NUM_TASKS),
            .IDX       (g),
            .IW        (IW),
            .CW        (CW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .count      (count_reg),
            .ctrl       (ctrl),
            .load       (load),
            .pick_idx   (ch_idx[NUM_TASKS]),
            .in_found   (ch_found[g]),
            .in_period  (ch_period[g]),
            .in_idx     (ch_idx[g]),
            .out_found  (ch_found[g+1]),
            .out_period (ch_period[g+1]),
            .out_idx    (ch_idx[g+1])
        );
    end

    rms_ctrl #(
        .NUM_TASKS (NUM_TASKS),
        .IW        (IW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_cmd     (s_tuser),
        .s_ready   (s_tready),
        .res_found (ch_found[NUM_TASKS]),
        .res_idx   (ch_idx[NUM_TASKS]),
        .ctrl      (ctrl),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_busy    (m_tuser),
        .m_task    (m_task)
    );

    assign m_tdata = {4'b0, m_task};

endmodule

[hdl/rms_checker.sv]
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rms_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 8'd0)
        else $error("idle result carries a task index");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during a tick");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rate_monotonic_scheduler_top rms_checker u_rms_checker (.*);

[dv/tb_rate_monotonic_scheduler_top.sv]
// ----------------------------------------------------------------------------
// tb_rate_monotonic_scheduler_top
// Self-checking bench for the rate-monotonic tick scheduler. Load and tick
// words are streamed in: first a directed table, then random task sets with
// tick runs under several idling mixes. A local scheduler model predicts
// each unpinned tick result, and each result word is compared in order.
// ----------------------------------------------------------------------------
module tb_rate_monotonic_scheduler_top
    import rms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_TASKS  = 16;
    localparam int SETTLE   = 2 * (N_TASKS + 3);
    localparam int HOLD_LEN = 500;
    localparam int WD_LIMIT = 4000;
    localparam int DIR_ROWS = 28;

    typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [15:0] ex;
        logic [15:0] per;
        logic        pinned;
        logic        busy;
        logic [3:0]  runner;
    } dir_row_t;

    typedef struct {
        logic       pinned;
        logic       busy;
        logic [3:0] runner;
    } word_tag_t;

    typedef struct {
        logic       busy;
        logic [3:0] runner;
    } tick_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata   = '0;  // task_index, exec_time, period_value
    logic                  s_tuser   = 1'b0;  // command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;   // running_task
    logic                  m_tuser;   // busy_res

    logic [TIME_W-1:0]     sched_exec      [N_TASKS];
    logic [TIME_W-1:0]     sched_period    [N_TASKS];
    logic [TIME_W-1:0]     sched_work      [N_TASKS];
    logic [TIME_W-1:0]     sched_countdown [N_TASKS];
    int                    sched_active;

    word_tag_t             word_tags[$];
    tick_result_t          tick_results_due[$];
    dir_row_t              dir_rows [DIR_ROWS];

    int mismatches   = 0;
    int words_sent   = 0;
    int loads_seen   = 0;
    int ticks_seen   = 0;
    int busy_seen    = 0;
    int cfg_writes   = 0;
    int stall_run    = 0;
    int src_pct      = 0;
    int sink_pct     = 0;
    int hold_req_id  = 0;
    int hold_seen_id = 0;
    int hold_left    = 0;

    rate_monotonic_scheduler_top #(.NUM_TASKS(N_TASKS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatches++;
        if (mismatches <= 30)
            $display("%0t: %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    endtask

    // release, pick shortest period (lowest index on ties), count down
    function automatic void schedule_tick(output logic busy, output logic [3:0] runner);
        logic hit;
        int   pick;
        hit  = 1'b0;
        pick = 0;
        for (int i = 0; i < sched_active; i++) begin
            if (sched_countdown[i] == 0) begin
                sched_work[i]      = sched_exec[i];
                sched_countdown[i] = sched_period[i];
            end
        end
        for (int i = 0; i < sched_active; i++) begin
            if (sched_work[i] != 0 && (!hit || sched_period[i] < sched_period[pick])) begin
                pick = i;
                hit  = 1'b1;
            end
        end
        if (hit)
            sched_work[pick] = sched_work[pick] - 1'b1;
        for (int i = 0; i < sched_active; i++) begin
            if (sched_countdown[i] != 0)
                sched_countdown[i] = sched_countdown[i] - 1'b1;
        end
        busy   = hit;
        runner = hit ? 4'(pick) : 4'd0;
    endfunction

    always @(posedge aclk) begin
        if (hold_seen_id != hold_req_id) begin
            hold_seen_id = hold_req_id;
            hold_left    = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_pct);
        end
    end

    always @(posedge aclk) begin
        word_tag_t    tag;
        tick_result_t due;
        tick_result_t got;
        logic         progress;
        progress = 1'b0;
        if (aresetn) begin
            if (cfg_wen)
                sched_active = (cfg_wdata > N_TASKS) ? N_TASKS : int'(cfg_wdata);
            if (s_tvalid && s_tready) begin
                progress = 1'b1;
                tag = word_tags.pop_front();
                if (s_tuser == CMD_LOAD) begin
                    sched_exec[s_tdata[3:0]]   = s_tdata[19:4];
                    sched_period[s_tdata[3:0]] = s_tdata[35:20];
                    loads_seen++;
                end else begin
                    schedule_tick(due.busy, due.runner);
                    if (tag.pinned) begin
                        due.busy   = tag.busy;
                        due.runner = tag.runner;
                    end
                    tick_results_due.push_back(due);
                    ticks_seen++;
                end
            end
            if (m_tvalid && m_tready) begin
                progress   = 1'b1;
                got.busy   = m_tuser;
                got.runner = m_tdata[3:0];
                if (tick_results_due.size() == 0) begin
                    report_mismatch("result word with none pending", -1, int'(got.runner));
                end else begin
                    due = tick_results_due.pop_front();
                    if (got.busy !== due.busy)
                        report_mismatch("busy_res", int'(due.busy), int'(got.busy));
                    if (got.runner !== due.runner)
                        report_mismatch("running_task", int'(due.runner), int'(got.runner));
                    if (got.busy === 1'b1)
                        busy_seen++;
                end
            end
        end
        stall_run = progress ? 0 : stall_run + 1;
    end

    initial begin
        while (stall_run < WD_LIMIT)
            @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(input logic cmd, input logic [3:0] idx, input logic [15:0] ex,
                             input logic [15:0] per, input logic pinned = 1'b0,
                             input logic busy = 1'b0, input logic [3:0] runner = 4'd0);
        while ($urandom_range(99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        word_tags.push_back('{pinned, busy, runner});
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, per, ex, idx};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
    endtask

    // let the monitor log the last accepted word before waiting for results
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tick_results_due.size() != 0)
            @(posedge aclk);
    endtask

    // loads leave no result, so let the last word clear the pipe too
    task automatic write_active(input logic [CFG_W-1:0] value);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [15:0] pick_time(input int hi);
        return ($urandom_range(99) < 10) ? 16'($urandom_range(65535)) : 16'($urandom_range(hi));
    endfunction

    task automatic run_episode();
        int          sel;
        int          n_ticks;
        logic [4:0]  count;
        sel = $urandom_range(99);
        if (sel < 6)
            count = 5'd0;
        else if (sel < 14)
            count = 5'($urandom_range(31, 17));
        else if (sel < 24)
            count = 5'(N_TASKS);
        else
            count = 5'($urandom_range(N_TASKS, 1));
        write_active(count);
        for (int i = 0; i < N_TASKS; i++) begin
            if (i < count && $urandom_range(99) < 80)
                send_word(CMD_LOAD, 4'(i), pick_time(4), pick_time(10));
        end
        n_ticks = $urandom_range(45, 15);
        for (int k = 0; k < n_ticks; k++) begin
            if ($urandom_range(99) < 8)
                send_word(CMD_LOAD, 4'($urandom_range(15)), pick_time(6), pick_time(12));
            send_tick();
        end
    endtask

    initial begin
        int target;
        for (int i = 0; i < N_TASKS; i++) begin
            sched_exec[i]      = '0;
            sched_period[i]    = '0;
            sched_work[i]      = '0;
            sched_countdown[i] = '0;
        end
        sched_active = 0;

        dir_rows = '{
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0},
            '{ROW_LOAD, 4'd0,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 4'd0},
            '{ROW_LOAD, 4'd15, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_LOAD, 4'd1,  16'd2,    16'd3,    1'b0, 1'b0, 4'd0},
            '{ROW_LOAD, 4'd2,  16'd1,    16'd3,    1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0},
            '{ROW_CFG,  4'd0,  16'd31,   16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b1, 4'd1},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_LOAD, 4'd1,  16'd5,    16'd1,    1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_CFG,  4'd0,  16'd2,    16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_LOAD, 4'd7,  16'd3,    16'd2,    1'b0, 1'b0, 4'd0},
            '{ROW_CFG,  4'd0,  16'd16,   16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_CFG,  4'd0,  16'd0,    16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0},
            '{ROW_CFG,  4'd0,  16'd17,   16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0},
            '{ROW_TICK, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_CFG: begin
                    write_active(dir_rows[r].ex[4:0]);
                end
                ROW_LOAD: begin
                    send_word(CMD_LOAD, dir_rows[r].idx, dir_rows[r].ex, dir_rows[r].per);
                end
                default: begin
                    send_word(CMD_TICK, dir_rows[r].idx, dir_rows[r].ex, dir_rows[r].per,
                              dir_rows[r].pinned, dir_rows[r].busy, dir_rows[r].runner);
                end
            endcase
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_pct = 0;  sink_pct = 0;  end
                1: begin src_pct = 76; sink_pct = 0;  end
                2: begin src_pct = 0;  sink_pct = 76; end
                default: begin src_pct = 13; sink_pct = 13; end
            endcase
            target = words_sent + 375;
            if (p == 0) begin
                // sink stalls long while ticks keep coming
                hold_req_id++;
                for (int k = 0; k < 40; k++)
                    send_tick();
                drain_results();
            end
            while (words_sent < target)
                run_episode();
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (tick_results_due.size() != 0)
            report_mismatch("results never delivered", 0, tick_results_due.size());

        $display("Covered %0d load words, %0d tick words (%0d busy, %0d idle), %0d count writes",
                 loads_seen, ticks_seen, busy_seen, ticks_seen - busy_seen, cfg_writes);
        $display("Idling mixes: none, sender, receiver, both; one long receiver hold-off");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
